>>> hdl/assert_macros.svh
// Assertion helpers shared by the noise block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define FVN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication under an active-low reset.
`define FVN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> hdl/fvn_pkg.sv
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants, types and the hash-to-unit mapping of the value noise block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fvn_pkg;

	// Fixed formats.
	localparam int FRAC_BITS       = 16;
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int COORD_W         = 32;
	localparam int NOISE_W         = 17;
	localparam int OCT_CNT_W       = 4;
	localparam int PERS_W          = 17;
	localparam int INV_W           = 24;
	localparam int SEED_W          = 32;
	localparam int QUOT_W          = 18;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 32;

	// Register map.
	typedef enum logic [1:0] {
		REG_OCTAVES    = 2'd0,
		REG_PERSIST    = 2'd1,
		REG_INV_PERIOD = 2'd2,
		REG_SEED       = 2'd3
	} reg_idx_t;

	// Register reset values.
	localparam logic [OCT_CNT_W-1:0] OCTAVES_RST = 4'd1;
	localparam logic [PERS_W-1:0]    PERSIST_RST = 17'd32768;
	localparam logic [INV_W-1:0]     INV_RST     = 24'd65536;
	localparam logic [SEED_W-1:0]    SEED_RST    = 32'd0;

	// Hash constants.
	localparam logic [31:0] HASH_KX    = 32'd72699;
	localparam logic [31:0] HASH_KY    = 32'd31976;
	localparam logic [31:0] HASH_KZ    = 32'd16863;
	localparam logic [31:0] HASH_KS    = 32'd561;
	localparam logic [31:0] HASH_MUL   = 32'd11126;
	localparam logic [31:0] HASH_ADD1  = 32'd98756;
	localparam logic [31:0] HASH_ADD2  = 32'd423005601;
	localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
	localparam int          HASH_SHIFT = 13;

	localparam logic [NOISE_W-1:0] NOISE_ONE = 17'd65536;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Maps a 31-bit hash to Q1.16 with rounding: (h*65536 + 2^30-1) / (2^31-1).
	// The quotient estimate x>>31 is off by at most one, fixed by one compare.
	function automatic logic [NOISE_W-1:0] hash_to_unit(input logic [31:0] h);
		logic [47:0]        x;
		logic [NOISE_W-1:0] q0;
		logic [31:0]        r0;
		x  = {1'b0, h[30:0], 16'b0} + 48'h3fffffff;
		q0 = x[47:31];
		r0 = {1'b0, x[30:0]} + 32'(q0);
		return (r0 >= HASH_MASK) ? q0 + 17'd1 : q0;
	endfunction

endpackage

`default_nettype wire

>>> hdl/fvn_sample_if.sv
// ----------------------------------------------------------------------------
// fvn_sample_if
// Valid/ready channel that carries one sample point per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fvn_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [fvn_pkg::COORD_W-1:0]  coord_x;
	logic signed [fvn_pkg::COORD_W-1:0]  coord_y;
	logic signed [fvn_pkg::COORD_W-1:0]  coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input coord_z,
		output ready);
endinterface

`default_nettype wire

>>> hdl/fvn_result_if.sv
// ----------------------------------------------------------------------------
// fvn_result_if
// Valid/ready channel that carries one noise value per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fvn_result_if;
	logic                         valid;
	logic                         ready;
	logic [fvn_pkg::NOISE_W-1:0]  noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

>>> hdl/fractal_value_noise_3d.sv
// ----------------------------------------------------------------------------
// fractal_value_noise_3d
// Fractal 3D value noise: scaled point, per-octave lattice hash, trilinear
// blend and weighted octave sum on one shared multiplier, then a normalizing divide.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                          Handshake
// sample    in   coord_x, coord_y, coord_z (Q16.16) valid/ready
// result    out  noise_value (Q1.16, 0..65536)    valid/ready
// config    in   APB registers 0..3 at 4*i        psel/penable/pwrite, pready=1
//
// For N octaves an item passes through a scaling step per axis, then per octave
// a setup step, 8 steps per corner hash, 7 blends and 2 weight steps, then the
// divide and an output step; with N=0 it goes from acceptance straight to the
// output step.
// The block takes one item at a time; sample.ready is high only while idle.
// A result waits in the output register while the next item is accepted.
// Reset is asynchronous and active low; it clears control and sets the config registers to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fractal_value_noise_3d #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fvn_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [fvn_pkg::PDATA_W-1:0]   pwdata,
	output logic      [fvn_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	fvn_sample_if.sink                         sample,
	fvn_result_if.source                       result
);
	import fvn_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
	localparam int W_W    = 17 + MAX_OCTAVES;
	localparam int WS_W   = W_W + OCT_W;
	localparam int ACC_W  = W_W + NOISE_W + OCT_W;
	localparam int NUM_W  = ACC_W + 1;
	localparam int MUL_W  = (W_W + 1 > 33) ? W_W + 1 : 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int S_W    = INV_W + F;
	localparam int SH_W   = S_W + MAX_OCTAVES + 8;
	localparam int SCL_LO = COORD_W - F;
	localparam int SCL_HI = COORD_W + INV_W - 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCALE, ST_SETUP, ST_HASH, ST_LERP,
		ST_ACCUM, ST_WEIGHT, ST_DIV, ST_OUT
	} state_t;

	// Configuration registers.
	logic [OCT_CNT_W-1:0] oct_cnt_q;
	logic [PERS_W-1:0]    pers_q;
	logic [INV_W-1:0]     inv_q;
	logic [SEED_W-1:0]    seed_q;

	// Control.
	state_t           state_q;
	logic [1:0]       axis_q;
	logic [OCT_W-1:0] oct_q;
	logic [OCT_W-1:0] n_oct_q;
	logic [2:0]       corner_q;
	logic [2:0]       hstep_q;
	logic [2:0]       lerp_q;
	logic             out_valid_q;

	// Datapath.
	logic signed [COORD_W-1:0] coord_q [3];
	logic signed [S_W-1:0]     s_q [3];
	logic [31:0]               c_q [3];
	logic [F-1:0]              f_q [3];
	logic [31:0]               hacc_q;
	logic [31:0]               hn_q;
	logic [31:0]               ht_q;
	logic [NOISE_W-1:0]        q_q [8];
	logic [W_W-1:0]            w_q;
	logic [WS_W-1:0]           wsum_q;
	logic [ACC_W-1:0]          acc_q;
	logic [NOISE_W-1:0]        res_q;
	logic [NOISE_W-1:0]        noise_q;

	// Combinational signals.
	logic                      in_fire;
	logic                      out_load;
	logic                      cfg_wr;
	logic [OCT_W-1:0]          n_clamp;
	logic                      last_oct;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [31:0]               p32;
	logic signed [COORD_W-1:0] coord_sel;
	logic [31:0]               seed_i;
	logic [31:0]               ccx;
	logic [31:0]               ccy;
	logic [31:0]               ccz;
	logic [31:0]               hsum;
	logic [31:0]               hmask;
	logic [31:0]               hxor;
	logic [31:0]               hfin;
	logic signed [17:0]        lerp_d;
	logic [F-1:0]              lerp_t;
	logic signed [PROD_W-1:0]  lerp_rnd;
	logic [17:0]               lerp_sum;
	logic [SH_W-1:0]           sh [3];
	logic [NUM_W-1:0]          div_num;
	logic                      div_start;
	div_stat_t                 div_stat;
	logic [QUOT_W-1:0]         div_quot;

	assign in_fire   = sample.valid && sample.ready;
	assign out_load  = !out_valid_q || result.ready;
	assign cfg_wr    = psel && penable && pwrite;
	assign n_clamp   = (32'(oct_cnt_q) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
		: OCT_W'(oct_cnt_q);
	assign last_oct  = (OCT_W'(oct_q + 1'b1) == n_oct_q);
	assign div_start = (state_q == ST_WEIGHT) && last_oct;
	assign div_num   = NUM_W'(acc_q) + NUM_W'(wsum_q >> 1);

	// APB register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cnt_q <= OCTAVES_RST;
			pers_q    <= PERSIST_RST;
			inv_q     <= INV_RST;
			seed_q    <= SEED_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_OCTAVES:    oct_cnt_q <= pwdata[OCT_CNT_W-1:0];
				REG_PERSIST:    pers_q    <= pwdata[PERS_W-1:0];
				REG_INV_PERIOD: inv_q     <= pwdata[INV_W-1:0];
				REG_SEED:       seed_q    <= pwdata[SEED_W-1:0];
				default:        ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_OCTAVES:    prdata = PDATA_W'(oct_cnt_q);
			REG_PERSIST:    prdata = PDATA_W'(pers_q);
			REG_INV_PERIOD: prdata = PDATA_W'(inv_q);
			REG_SEED:       prdata = PDATA_W'(seed_q);
			default:        prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// Operand terms for the hash steps.
	always_comb begin
		seed_i = seed_q + 32'(oct_q);
		ccx    = c_q[0] + 32'(corner_q[0]);
		ccy    = c_q[1] + 32'(corner_q[1]);
		ccz    = c_q[2] + 32'(corner_q[2]);
		case (axis_q)
			2'd0:    coord_sel = coord_q[0];
			2'd1:    coord_sel = coord_q[1];
			default: coord_sel = coord_q[2];
		endcase
		lerp_d = $signed({1'b0, q_q[1]}) - $signed({1'b0, q_q[0]});
		if (lerp_q < 3'd4) begin
			lerp_t = f_q[0];
		end else if (lerp_q < 3'd6) begin
			lerp_t = f_q[1];
		end else begin
			lerp_t = f_q[2];
		end
	end

	// Shared multiplier operand select.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SCALE: begin
				mul_a = MUL_W'(coord_sel);
				mul_b = MUL_W'(inv_q);
			end
			ST_HASH: begin
				case (hstep_q)
					3'd0: begin
						mul_a = MUL_W'(ccx);
						mul_b = MUL_W'(HASH_KX);
					end
					3'd1: begin
						mul_a = MUL_W'(ccy);
						mul_b = MUL_W'(HASH_KY);
					end
					3'd2: begin
						mul_a = MUL_W'(ccz);
						mul_b = MUL_W'(HASH_KZ);
					end
					3'd3: begin
						mul_a = MUL_W'(seed_i);
						mul_b = MUL_W'(HASH_KS);
					end
					3'd4: begin
						mul_a = MUL_W'(hn_q);
						mul_b = MUL_W'(hn_q);
					end
					3'd5: begin
						mul_a = MUL_W'(ht_q);
						mul_b = MUL_W'(HASH_MUL);
					end
					3'd6: begin
						mul_a = MUL_W'(hn_q);
						mul_b = MUL_W'(ht_q);
					end
					default: ;
				endcase
			end
			ST_LERP: begin
				mul_a = MUL_W'(lerp_d);
				mul_b = MUL_W'(lerp_t);
			end
			ST_ACCUM: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(q_q[0]);
			end
			ST_WEIGHT: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(pers_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign p32   = mul_p[31:0];

	// Hash post-processing and blend rounding.
	always_comb begin
		hsum     = hacc_q + p32;
		hmask    = hsum & HASH_MASK;
		hxor     = (hmask >> HASH_SHIFT) ^ hmask;
		hfin     = (p32 + HASH_ADD2) & HASH_MASK;
		lerp_rnd = (mul_p + (PROD_W'(1) <<< (F - 1))) >>> F;
		lerp_sum = {1'b0, q_q[0]} + lerp_rnd[17:0];
	end

	// Lattice cell and fraction of the current octave.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh[k] = SH_W'(s_q[k]) << oct_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			oct_q       <= '0;
			n_oct_q     <= '0;
			corner_q    <= '0;
			hstep_q     <= '0;
			lerp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready && !(state_q == ST_OUT && out_load)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						n_oct_q <= n_clamp;
						axis_q  <= '0;
						oct_q   <= '0;
						state_q <= (n_clamp == '0) ? ST_OUT : ST_SCALE;
					end
				end
				ST_SCALE: begin
					axis_q <= axis_q + 1'b1;
					if (axis_q == 2'd2) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					corner_q <= '0;
					hstep_q  <= '0;
					state_q  <= ST_HASH;
				end
				ST_HASH: begin
					hstep_q <= hstep_q + 1'b1;
					if (hstep_q == 3'd7) begin
						corner_q <= corner_q + 1'b1;
						if (corner_q == 3'd7) begin
							lerp_q  <= '0;
							state_q <= ST_LERP;
						end
					end
				end
				ST_LERP: begin
					lerp_q <= lerp_q + 1'b1;
					if (lerp_q == 3'd6) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					state_q <= ST_WEIGHT;
				end
				ST_WEIGHT: begin
					if (last_oct) begin
						state_q <= ST_DIV;
					end else begin
						oct_q   <= OCT_W'(oct_q + 1'b1);
						state_q <= ST_SETUP;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					coord_q[0] <= sample.coord_x;
					coord_q[1] <= sample.coord_y;
					coord_q[2] <= sample.coord_z;
					w_q        <= W_W'(NOISE_ONE);
					wsum_q     <= '0;
					acc_q      <= '0;
					res_q      <= '0;
				end
			end
			ST_SCALE: begin
				s_q[axis_q] <= mul_p[SCL_HI:SCL_LO];
			end
			ST_SETUP: begin
				for (int k = 0; k < 3; k++) begin
					c_q[k] <= sh[k][F+31:F];
					f_q[k] <= sh[k][F-1:0];
				end
			end
			ST_HASH: begin
				case (hstep_q)
					3'd0:    hacc_q <= p32;
					3'd1:    hacc_q <= hsum;
					3'd2:    hacc_q <= hsum;
					3'd3:    hn_q   <= hxor;
					3'd4:    ht_q   <= p32;
					3'd5:    ht_q   <= p32 + HASH_ADD1;
					3'd6:    hn_q   <= hfin;
					default: begin
						// Corner values enter at the top and settle in order.
						for (int k = 0; k < 7; k++) begin
							q_q[k] <= q_q[k+1];
						end
						q_q[7] <= hash_to_unit(hn_q);
					end
				endcase
			end
			ST_LERP: begin
				// Consume the two oldest values and queue the blend behind the rest.
				for (int k = 0; k < 6; k++) begin
					q_q[k] <= (k == 6 - int'(lerp_q)) ? lerp_sum[NOISE_W-1:0] : q_q[k+2];
				end
				if (lerp_q == 3'd0) begin
					q_q[6] <= lerp_sum[NOISE_W-1:0];
				end
			end
			ST_ACCUM: begin
				acc_q  <= acc_q + ACC_W'(mul_p);
				wsum_q <= wsum_q + WS_W'(w_q);
			end
			ST_WEIGHT: begin
				w_q <= W_W'((mul_p + PROD_W'(32768)) >>> 16);
			end
			ST_DIV: begin
				if (div_stat.done) begin
					res_q <= (div_quot > QUOT_W'(NOISE_ONE)) ? NOISE_ONE
						: div_quot[NOISE_W-1:0];
				end
			end
			ST_OUT: begin
				if (out_load) begin
					noise_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// Final normalization by the weight sum.
	fvn_div #(
		.NUM_W (NUM_W),
		.DEN_W (WS_W),
		.Q_W   (QUOT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (wsum_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	assign sample.ready       = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.noise_value = noise_q;

	`FVN_ASSERT_IMP(a_out_range, clk, arst_n, out_valid_q, noise_q <= NOISE_ONE, "noise out of range")
	`FVN_ASSERT_IMP(a_div_state, clk, arst_n, div_stat.busy, state_q == ST_DIV, "divider busy outside divide")
	`FVN_ASSERT_IMP(a_oct_range, clk, arst_n, state_q == ST_HASH, oct_q < n_oct_q, "octave index past count")

endmodule

`default_nettype wire

>>> hdl/fvn_div.sv
// ----------------------------------------------------------------------------
// fvn_div
// Restoring divider, one quotient bit per cycle, for the final normalization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fvn_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 29,
	parameter int Q_W   = 18
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUM_W-1:0]   num,
	input  wire logic [DEN_W-1:0]   den,
	output fvn_pkg::div_stat_t      stat,
	output logic      [Q_W-1:0]     quot
);
	import fvn_pkg::*;

	localparam int CNT_W = $clog2(Q_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// Trial subtraction; the caller guarantees num >> Q_W is below den.
	always_comb begin
		trial = {rem_q, quo_q[Q_W-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> Q_W);
			quo_q <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

	`FVN_ASSERT_IMP(a_done_not_busy, clk, arst_n, done_q, !busy_q, "divider done while busy")
	`FVN_ASSERT_NXT(a_start_busy, clk, arst_n, start, busy_q, "divider did not start")
	`FVN_ASSERT_IMP(a_busy_cnt, clk, arst_n, busy_q, cnt_q != '0, "divider count ran out")

endmodule

`default_nettype wire

>>> sim/tb_fractal_value_noise_3d.sv
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_3d
// Self-checking bench for the fractal value noise block: a directed table of
// points and register settings, then random points over several register
// settings and handshake pressures, each result checked against a local model or a table value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fractal_value_noise_3d;
	import fvn_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int PHASES = 8;

	// Idling modes of the two channels.
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [OCT_CNT_W-1:0] oct;
		logic [INV_W-1:0]     inv;
		logic [31:0]          x;
		logic [31:0]          y;
		logic [31:0]          z;
		bit                   known;
		logic [NOISE_W-1:0]   val;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	fvn_sample_if sample_ch();
	fvn_result_if result_ch();

	// Register copies used by the noise model.
	logic [OCT_CNT_W-1:0] octaves_cfg = OCTAVES_RST;
	logic [PERS_W-1:0]    persist_cfg = PERSIST_RST;
	logic [INV_W-1:0]     inv_cfg = INV_RST;
	logic [SEED_W-1:0]    seed_cfg = SEED_RST;

	logic [NOISE_W-1:0] noise_due[$];
	idle_mode_t idle_mode = IDLE_NONE;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;

	fractal_value_noise_3d dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample(sample_ch), .result(result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.coord_x = '0;
		sample_ch.coord_y = '0;
		sample_ch.coord_z = '0;
		result_ch.ready = 1'b0;
	end

	// Lattice corner hash mapped to Q1.16 with rounding.
	function automatic logic [63:0] corner_unit(logic [31:0] cx, logic [31:0] cy,
		logic [31:0] cz, logic [31:0] sd);
		logic [31:0] n;
		logic [63:0] q;
		n = HASH_KX * cx + HASH_KY * cy + HASH_KZ * cz + HASH_KS * sd;
		n = n & HASH_MASK;
		n = (n >> HASH_SHIFT) ^ n;
		n = n * (n * n * HASH_MUL + HASH_ADD1) + HASH_ADD2;
		n = n & HASH_MASK;
		q = ({32'b0, n} * 64'd65536 + 64'h3fffffff) / 64'h7fffffff;
		return q;
	endfunction

	function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] t);
		logic [63:0] one;
		one = 64'd1 << FRAC_BITS;
		return (a * (one - t) + b * t + (one >> 1)) >> FRAC_BITS;
	endfunction

	// Normalized fractal noise at one point under the current registers.
	function automatic logic [NOISE_W-1:0] fractal_noise(logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		longint scaled[3];
		logic [31:0] pt[3];
		logic [31:0] lat[3];
		logic [63:0] frac[3];
		logic [63:0] p, v[8], acc, wsum, w, r, x00, x10, x01, x11, y0, y1;
		int n;
		pt[0] = x;
		pt[1] = y;
		pt[2] = z;
		n = (octaves_cfg > 8) ? 8 : int'(octaves_cfg);
		if (n == 0)
			return '0;
		for (int k = 0; k < 3; k++)
			scaled[k] = (longint'(signed'(pt[k])) * longint'({40'b0, inv_cfg})) >>> 16;
		acc = 0;
		wsum = 0;
		w = 64'd65536;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				p = 64'(scaled[k]) << i;
				lat[k] = p[47:16];
				frac[k] = {48'b0, p[15:0]};
			end
			for (int k = 0; k < 8; k++)
				v[k] = corner_unit(lat[0] + 32'(k & 1), lat[1] + 32'((k >> 1) & 1),
					lat[2] + 32'((k >> 2) & 1), seed_cfg + 32'(i));
			x00 = blend(v[0], v[1], frac[0]);
			x10 = blend(v[2], v[3], frac[0]);
			x01 = blend(v[4], v[5], frac[0]);
			x11 = blend(v[6], v[7], frac[0]);
			y0 = blend(x00, x10, frac[1]);
			y1 = blend(x01, x11, frac[1]);
			acc += w * blend(y0, y1, frac[2]);
			wsum += w;
			w = (w * {47'b0, persist_cfg} + 64'd32768) >> 16;
		end
		r = (acc + (wsum >> 1)) / wsum;
		if (r > 64'd65536)
			r = 64'd65536;
		return r[NOISE_W-1:0];
	endfunction

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d results outstanding", $time,
				noise_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: stalls at random in the modes that ask for it.
	always @(posedge clk) begin
		if (idle_mode == IDLE_RECV)
			result_ch.ready <= ($urandom_range(99) >= 81);
		else if (idle_mode == IDLE_BOTH)
			result_ch.ready <= ($urandom_range(99) >= 16);
		else
			result_ch.ready <= 1'b1;
	end

	// Compare each accepted result with the oldest outstanding value.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (noise_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %0d", $time,
					result_ch.noise_value);
			end else if (noise_due[0] !== result_ch.noise_value) begin
				mismatches++;
				$display("%0t: noise_value expected %0d, actual %0d", $time, noise_due[0],
					result_ch.noise_value);
				void'(noise_due.pop_front());
			end else begin
				void'(noise_due.pop_front());
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_OCTAVES: octaves_cfg = value[OCT_CNT_W-1:0];
			REG_PERSIST: persist_cfg = value[PERS_W-1:0];
			REG_INV_PERIOD: inv_cfg = value[INV_W-1:0];
			REG_SEED: seed_cfg = value;
			default: ;
		endcase
	endtask

	// Wait until every outstanding result has come back and the block is idle.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (noise_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [3:0] oct, logic [16:0] pers, logic [23:0] inv,
		logic [31:0] sd);
		drain();
		reg_write(REG_OCTAVES, 32'(oct));
		reg_write(REG_PERSIST, 32'(pers));
		reg_write(REG_INV_PERIOD, 32'(inv));
		reg_write(REG_SEED, sd);
	endtask

	// Offer one point; valid stays high after acceptance unless a gap follows.
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit known,
		logic [NOISE_W-1:0] val);
		logic [NOISE_W-1:0] due;
		due = known ? val : fractal_noise(x, y, z);
		while ((idle_mode == IDLE_SEND && $urandom_range(99) < 81) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 16)) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.coord_x <= x;
		sample_ch.coord_y <= y;
		sample_ch.coord_z <= z;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		noise_due.push_back(due);
		items_sent++;
	endtask

	// Random coordinate: full range, small values, whole negative numbers, or values within one unit of zero.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($urandom_range(1 << 20)) - 32'(1 << 19);
			2: return {16'(-$urandom_range(1, 200)), 16'h0};
			default: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom())};
		endcase
	endfunction

	initial begin
		point_row_t rows[$];
		logic [3:0] oct;
		rows = '{
			'{4'd0, 24'd65536, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 17'd0},
			'{4'd0, 24'd65536, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 17'd0},
			'{4'd0, 24'd65536, 32'hffffffff, 32'h00000000, 32'h12345678, 1'b1, 17'd0},
			'{4'd1, 24'd65536, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 17'd0},
			'{4'd1, 24'd65536, 32'hffff0000, 32'hfffe0000, 32'h80000000, 1'b0, 17'd0},
			'{4'd1, 24'd65536, 32'h00008000, 32'h00008000, 32'h00008000, 1'b0, 17'd0},
			'{4'd1, 24'd65536, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b0, 17'd0},
			'{4'd1, 24'd65536, 32'h0000ffff, 32'hffff0001, 32'h00010000, 1'b0, 17'd0},
			'{4'd1, 24'd0, 32'h12345678, 32'h9abcdef0, 32'h7fffffff, 1'b0, 17'd0},
			'{4'd1, 24'd0, 32'h80000000, 32'hffffffff, 32'h00000001, 1'b0, 17'd0},
			'{4'd8, 24'hffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 17'd0},
			'{4'd8, 24'hffffff, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 17'd0},
			'{4'd8, 24'd1, 32'hdeadbeef, 32'h00000001, 32'hfffffffe, 1'b0, 17'd0},
			'{4'd15, 24'd65536, 32'h00018000, 32'hfffe8000, 32'h00000000, 1'b0, 17'd0},
			'{4'd9, 24'd65536, 32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 1'b0, 17'd0},
			'{4'd2, 24'd98304, 32'hfffd0000, 32'h00030000, 32'hfffffff0, 1'b0, 17'd0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset seed and persistence.
		foreach (rows[r]) begin
			if (rows[r].oct != octaves_cfg || rows[r].inv != inv_cfg) begin
				drain();
				reg_write(REG_OCTAVES, 32'(rows[r].oct));
				reg_write(REG_INV_PERIOD, 32'(rows[r].inv));
			end
			send_point(rows[r].x, rows[r].y, rows[r].z, rows[r].known, rows[r].val);
		end

		// Random part: each phase has its own registers and handshake pressure.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_config(4'd8, 17'd65536, 24'hffffff, 32'h80000000);
				1: set_config(4'd15, 17'd0, 24'd1, 32'h7fffffff);
				2: set_config(4'd0, 17'd12345, 24'd4096, 32'hffffffff);
				default: begin
					oct = 4'($urandom_range(1, 6));
					if ($urandom_range(3) == 0)
						oct = 4'($urandom_range(9, 15));
					set_config(oct, 17'($urandom_range(65536)),
						24'($urandom_range(1, 24'hffffff)), $urandom());
				end
			endcase
			idle_mode = idle_mode_t'(ph % 4);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
		end

		drain();
		repeat (700) @(posedge clk);
		$display("Checked %0d noise results from %0d points over %0d register settings,",
			results_seen, items_sent, PHASES + 1);
		$display("with sender gaps and receiver stalls in turn; %0d mismatches.", mismatches);
		if (mismatches == 0 && noise_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
